/* sv/upst_pkg.sv */
`timescale 1ns / 1ps

package upst_pkg;

    // Table geometry.
    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Fixed field widths of the request and response.
    localparam int CMD_BITS   = 3;
    localparam int FIELD_BITS = 32;
    localparam int COUNT_BITS = 7;
    localparam int ENTRY_BITS = 2 * FIELD_BITS;

    // Only the low VALUE_BITS bits of each member take part.
    localparam logic [FIELD_BITS-1:0] VALUE_MASK =
        FIELD_BITS'((64'd1 << VALUE_BITS) - 64'd1);

    // Command codes.
    localparam logic [CMD_BITS-1:0] CMD_INSERT       = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_REMOVE_PAIR  = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_REMOVE_VALUE = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_CONTAINS     = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR        = 3'd4;

    // Request payload.
    typedef struct packed {
        logic [CMD_BITS-1:0]   cmd;
        logic [FIELD_BITS-1:0] first_value;
        logic [FIELD_BITS-1:0] second_value;
    } upst_req_t;

endpackage

/* sv/upst_req_if.sv */
`timescale 1ns / 1ps

// Request channel: one command with its pair or value.
interface upst_req_if
    import upst_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CMD_BITS-1:0]   cmd;
    logic [FIELD_BITS-1:0] first_value;
    logic [FIELD_BITS-1:0] second_value;

    modport source (output valid, cmd, first_value, second_value, input ready);
    modport sink   (input valid, cmd, first_value, second_value, output ready);
endinterface

/* sv/upst_rsp_if.sv */
`timescale 1ns / 1ps

// Response channel: found flag, status and the count after the command.
interface upst_rsp_if
    import upst_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  found;
    logic                  status;
    logic [COUNT_BITS-1:0] count;

    modport source (output valid, found, status, count, input ready);
    modport sink   (input valid, found, status, count, output ready);
endinterface

/* sv/upst_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module upst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; a read of the written address
    // returns the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* sv/unordered_pair_set_table_top.sv */
`timescale 1ns / 1ps
// Insert, clear and unknown commands show their response in the cycle after the request is
// taken. Remove and contains scan one entry per cycle from the table RAM's read port, except
// while a removal moves the last entry into the matching slot.
// One request at a time; the next can be taken in the cycle after the response is taken.
// Reset clears the count and the sequencer; the table RAM is not cleared.
module unordered_pair_set_table_top
    import upst_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    upst_req_if.sink       req,
    upst_rsp_if.source     rsp
);
    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SEEK = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_MOVE = 3'd3;
    localparam logic [2:0] ST_RESP = 3'd4;

    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    logic [2:0]            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CMD_BITS-1:0]   cmd_reg, cmd_next;
    logic [FIELD_BITS-1:0] a_reg, a_next;
    logic [FIELD_BITS-1:0] b_reg, b_next;
    logic                  found_reg, found_next;
    logic                  status_reg, status_next;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENTRY_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENTRY_BITS-1:0] ram_rdata;

    logic                  req_fire;
    logic [FIELD_BITS-1:0] req_a, req_b;
    logic [FIELD_BITS-1:0] ent_hi, ent_lo;
    logic                  pair_hit, value_hit, hit;
    logic [CNT_W-1:0]      idx_inc;
    logic [CNT_W-1:0]      count_dec;

    upst_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (CAPACITY)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake and masked operands.
    assign req.ready  = (state_reg == ST_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign req_a      = req.first_value & VALUE_MASK;
    assign req_b      = req.second_value & VALUE_MASK;

    assign rsp.valid  = (state_reg == ST_RESP);
    assign rsp.found  = found_reg;
    assign rsp.status = status_reg;
    assign rsp.count  = COUNT_BITS'(count_reg);

    // Shared compare unit on the entry read last cycle.
    assign ent_hi    = ram_rdata[ENTRY_BITS-1:FIELD_BITS];
    assign ent_lo    = ram_rdata[FIELD_BITS-1:0];
    assign pair_hit  = ((ent_hi == a_reg) && (ent_lo == b_reg)) ||
                       ((ent_hi == b_reg) && (ent_lo == a_reg));
    assign value_hit = (ent_hi == a_reg) || (ent_lo == a_reg);
    assign hit       = (cmd_reg == CMD_REMOVE_VALUE) ? value_hit : pair_hit;
    assign idx_inc   = idx_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;

    // Sequencer: seek issues a read, scan compares one entry per cycle until a hit,
    // move copies the last entry into the matching slot.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        cmd_next    = cmd_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        found_next  = found_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = count_reg[IDX_W-1:0];
        ram_wdata   = {req_a, req_b};
        ram_raddr   = idx_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    cmd_next    = req.cmd;
                    a_next      = req_a;
                    b_next      = req_b;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    status_next = 1'b0;
                    state_next  = ST_RESP;
                    case (req.cmd)
                        CMD_INSERT:
                        begin
                            if (count_reg < CAP_COUNT)
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                        end
                        CMD_REMOVE_PAIR, CMD_REMOVE_VALUE, CMD_CONTAINS:
                        begin
                            state_next = ST_SEEK;
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_SEEK:
            begin
                ram_raddr = idx_reg[IDX_W-1:0];
                if (idx_reg < count_reg)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    if (cmd_reg == CMD_CONTAINS)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        ram_raddr  = count_dec[IDX_W-1:0];
                        state_next = ST_MOVE;
                    end
                end
                else
                begin
                    idx_next  = idx_inc;
                    ram_raddr = idx_inc[IDX_W-1:0];
                    if (idx_inc >= count_reg)
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_MOVE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[IDX_W-1:0];
                ram_wdata  = ram_rdata;
                count_next = count_dec;
                // Remove value checks the refilled slot again.
                state_next = (cmd_reg == CMD_REMOVE_PAIR) ? ST_RESP : ST_SEEK;
            end
            ST_RESP:
            begin
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            found_reg  <= 1'b0;
            status_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            found_reg  <= found_next;
            status_reg <= status_next;
        end
    end

    // Operand and scan index registers.
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        cmd_reg <= cmd_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    // The count never passes the table size.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CAP_COUNT)
        else $error("entry count above capacity");

    // A scan only compares entries below the count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg < count_reg))
        else $error("scan index outside the stored entries");

    // Each move removes exactly one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOVE) |=> (count_reg == $past(count_dec)))
        else $error("move did not drop one entry");

    // A dropped insert is reported only with a full table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status) |-> (count_reg == CAP_COUNT && !rsp.found))
        else $error("full status with room left");

    // Table writes stay within the entries in use or the next free slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == ST_IDLE && count_reg < CAP_COUNT) ||
                    (state_reg == ST_MOVE && idx_reg < count_reg)))
        else $error("table write outside the live range");
endmodule
